/* rtl/mac_policy_filter_table_macros.svh */
// Assertion macros shared by the filter table RTL.
// Included by modules that carry concurrent checks.
`ifndef MAC_POLICY_FILTER_TABLE_MACROS_SVH
`define MAC_POLICY_FILTER_TABLE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define MPF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication outside reset.
`define MPF_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mpft_pkg.sv */
// Shared types and constants for the device address filter table.
// No dependencies.
`timescale 1ns / 1ps
package mpft_pkg;
    localparam int TABLE_DEPTH  = 32;
    localparam int SNOOZE_DEPTH = 32;
    localparam int CLASS_COUNT  = 16;
    localparam int TIDX_W = $clog2(TABLE_DEPTH);
    localparam int SIDX_W = $clog2(SNOOZE_DEPTH);
    localparam int CNT_W  = 6;
    localparam int MAC_W  = 48;
    localparam int CLS_W  = 8;

    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0, OP_SET = 3'd1, OP_ADD = 3'd2, OP_REMOVE = 3'd3,
        OP_SNOOZE = 3'd4, OP_CLEAR = 3'd5, OP_READ = 3'd6, OP_BAD = 3'd7
    } op_t;

    localparam logic [1:0] POL_NORMAL = 2'd0;
    localparam logic [1:0] POL_IGNORE = 2'd1;
    localparam logic [1:0] POL_TRUST  = 2'd2;
    localparam logic [1:0] POL_ALERT  = 2'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic              load;      // capture input beat
        logic              tscan;     // compare table row at scan index
        logic              sscan;     // compare snooze row at scan index
        logic [TIDX_W-1:0] tidx;      // table read address
        logic [SIDX_W-1:0] sidx;      // snooze read address
        logic              rd_last;   // read last row (for remove move)
        logic              commit;    // apply update and build result
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] sfill;
    } stat_t;
endpackage

/* rtl/mac_policy_filter_table.sv */
// Top level of the device address filter table: controller plus datapath.
// Depends on mpft_pkg, mpft_ctrl, mpft_dp (and mpft_ram through mpft_dp).
//
//  channel | direction | handshake              | payload
//  in      | sink      | in_valid / in_stall    | opcode device_mac det_class policy_code entry_index
//  out     | source    | out_valid / out_stall  | op_status entry_found device_policy is_silenced
//          |           |                        | entry_mac entry_class entry_total
//  cfg     | sink      | cfg_valid / cfg_ready  | cfg_data (unknown class code)
//
// A result is built by scanning rows up to count_max, where count_max is
// the larger of the table entry count and the snooze fill, row by row
// through the single read port of each RAM, then a last-row read and commit.
// Reset clears counts and control; RAM contents stay undefined until written.
// A new input beat is taken only once the previous result has left the output
// register; out_stall holds the result as long as needed.
`timescale 1ns / 1ps
module mac_policy_filter_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     opcode,
    input  logic [mpft_pkg::MAC_W-1:0]     device_mac,
    input  logic [mpft_pkg::CLS_W-1:0]     det_class,
    input  logic [2:0]                     policy_code,
    input  logic [7:0]                     entry_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           op_status,
    output logic                           entry_found,
    output logic [1:0]                     device_policy,
    output logic                           is_silenced,
    output logic [mpft_pkg::MAC_W-1:0]     entry_mac,
    output logic [mpft_pkg::CLS_W-1:0]     entry_class,
    output logic [mpft_pkg::CNT_W-1:0]     entry_total,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpft_pkg::CLS_W-1:0]     cfg_data
);
    import mpft_pkg::*;

    cmd_t             cmd;
    stat_t            stat;
    logic             busy;
    logic [CLS_W-1:0] unk_reg;

    // Hold off register writes while a beat is being processed.
    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unk_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unk_reg <= cfg_data;
        end
    end

    mpft_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .stat(stat), .cmd(cmd),
        .busy(busy)
    );

    mpft_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .opcode(opcode), .device_mac(device_mac), .det_class(det_class),
        .policy_code(policy_code), .entry_index(entry_index), .unk(unk_reg),
        .out_stall(out_stall), .out_valid(out_valid), .op_status(op_status),
        .entry_found(entry_found), .device_policy(device_policy),
        .is_silenced(is_silenced), .entry_mac(entry_mac),
        .entry_class(entry_class), .entry_total(entry_total)
    );
endmodule

/* rtl/mpft_ram.sv */
// Generic single-write RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module mpft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/mpft_ctrl.sv */
// Sequencer for the filter table: scans table and snooze ring, then commits.
// Depends on mpft_pkg and mac_policy_filter_table_macros.svh.
`timescale 1ns / 1ps
`include "mac_policy_filter_table_macros.svh"
module mpft_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            out_valid,
    input  mpft_pkg::stat_t stat,
    output mpft_pkg::cmd_t  cmd,
    output logic            busy
);
    import mpft_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_LAST  = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    // Scan issues addr idx; compare happens next cycle, so run one past.
    logic tin, sin;
    assign tin = idx_reg < stat.count;
    assign sin = idx_reg < stat.sfill;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.tidx   = idx_reg[TIDX_W-1:0];
        cmd.sidx   = idx_reg[SIDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !out_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Row read now lands next cycle; compare flag is registered.
                cmd.tscan = tin;
                cmd.sscan = sin;
                idx_next  = idx_reg + 1'b1;
                if (!tin && !sin)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // Read the last row for a move.
                cmd.rd_last = 1'b1;
                cmd.tidx    = stat.count[TIDX_W-1:0] - 1'b1;
                state_next  = ST_WAIT;
            end
            ST_WAIT:
            begin
                cmd.tidx   = stat.count[TIDX_W-1:0] - 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE) || out_valid;
    assign busy     = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    `MPF_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `MPF_ASSERT_NXT(a_done_idle, clk, rst_n, state_reg == ST_DONE, state_reg == ST_IDLE,
                    "commit not followed by idle")
    `MPF_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_reg == ST_IDLE && !out_valid,
                    "load outside idle")
endmodule

/* rtl/mpft_dp.sv */
// Datapath: table and snooze RAMs, match flags, update and result registers.
// Depends on mpft_pkg, mpft_ram and mac_policy_filter_table_macros.svh.
`timescale 1ns / 1ps
`include "mac_policy_filter_table_macros.svh"
module mpft_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpft_pkg::cmd_t                 cmd,
    output mpft_pkg::stat_t                stat,
    input  logic [2:0]                     opcode,
    input  logic [mpft_pkg::MAC_W-1:0]     device_mac,
    input  logic [mpft_pkg::CLS_W-1:0]     det_class,
    input  logic [2:0]                     policy_code,
    input  logic [7:0]                     entry_index,
    input  logic [mpft_pkg::CLS_W-1:0]     unk,
    input  logic                           out_stall,
    output logic                           out_valid,
    output logic                           op_status,
    output logic                           entry_found,
    output logic [1:0]                     device_policy,
    output logic                           is_silenced,
    output logic [mpft_pkg::MAC_W-1:0]     entry_mac,
    output logic [mpft_pkg::CLS_W-1:0]     entry_class,
    output logic [mpft_pkg::CNT_W-1:0]     entry_total
);
    import mpft_pkg::*;

    localparam int ROW_W = MAC_W + CLS_W + 2;

    // Captured beat.
    op_t               op_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [CLS_W-1:0]  cls_reg;
    logic [2:0]        pol_reg;
    logic [7:0]        eidx_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  sfill_reg;
    logic [SIDX_W-1:0] snext_reg;

    logic              tfound_reg, sfound_reg;
    logic [TIDX_W-1:0] hit_reg;
    logic [1:0]        hpol_reg;
    logic [CLS_W-1:0]  hcls_reg;
    logic              tv_reg, sv_reg;
    logic [TIDX_W-1:0] tvidx_reg;
    logic [ROW_W-1:0]  last_row_reg;
    logic              lv_reg;

    // Table and snooze RAM access
    logic              t_we;
    logic [TIDX_W-1:0] t_waddr, t_raddr;
    logic [ROW_W-1:0]  t_wdata, t_rdata;
    logic              s_we;
    logic [MAC_W-1:0]  s_rdata;

    mpft_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_tab (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );
    mpft_ram #(.WIDTH(MAC_W), .DEPTH(SNOOZE_DEPTH)) u_snz (
        .clk(clk), .we(s_we), .waddr(snext_reg), .wdata(mac_reg),
        .raddr(cmd.sidx), .rdata(s_rdata)
    );

    // read entry goes through table address during the tail reads
    logic rd_op;
    logic eidx_ok;
    assign rd_op   = (op_reg == OP_READ);
    assign eidx_ok = ({1'b0, eidx_reg} < {1'b0, count_reg, 2'b0} >> 2) && (eidx_reg < TABLE_DEPTH);
    assign t_raddr = (rd_op && !cmd.tscan && !tv_reg) ? eidx_reg[TIDX_W-1:0] : cmd.tidx;

    logic [MAC_W-1:0] r_mac;
    logic [CLS_W-1:0] r_cls;
    logic [1:0]       r_pol;
    assign {r_mac, r_cls, r_pol} = t_rdata;

    function automatic logic [CLS_W-1:0] clean(input logic [CLS_W-1:0] c,
                                               input logic [CLS_W-1:0] u);
        return (c < CLASS_COUNT) ? c : u;
    endfunction

    // Commit decode
    logic [CLS_W-1:0]  ccls;
    logic [1:0]        apol;
    logic              do_apply, status, ins_full;
    logic [TIDX_W-1:0] last_idx;
    logic              found_o;
    logic [1:0]        rpol_o;
    logic              sil_o;
    logic [MAC_W-1:0]  rmac_o;
    logic [CLS_W-1:0]  rcls_o;

    always_comb
    begin
        ccls     = clean(cls_reg, unk);
        apol     = pol_reg[1:0];
        do_apply = 1'b0;
        status   = 1'b0;
        found_o  = tfound_reg;
        rpol_o   = POL_NORMAL;
        sil_o    = 1'b0;
        rmac_o   = '0;
        rcls_o   = '0;
        s_we     = 1'b0;
        last_idx = count_reg[TIDX_W-1:0] - 1'b1;
        case (op_reg)
            OP_LOOKUP:
            begin
                rpol_o = tfound_reg ? hpol_reg : POL_NORMAL;
                sil_o  = (rpol_o == POL_IGNORE) || (rpol_o == POL_TRUST) ||
                         ((rpol_o == POL_NORMAL) && sfound_reg);
            end
            OP_SET:
            begin
                if (pol_reg > 3'd3)
                begin
                    status = 1'b1;
                end
                else
                begin
                    do_apply = 1'b1;
                end
            end
            OP_ADD:
            begin
                apol = POL_IGNORE;
                if (tfound_reg && hpol_reg == POL_IGNORE)
                begin
                    status = 1'b1;
                end
                else
                begin
                    do_apply = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                apol = POL_NORMAL;
                ccls = unk;
                if (!tfound_reg)
                begin
                    status = 1'b1;
                end
                else
                begin
                    do_apply = 1'b1;
                end
            end
            OP_SNOOZE:
            begin
                s_we = cmd.commit && !sfound_reg;
            end
            OP_CLEAR:
            begin
                found_o = 1'b0;
            end
            OP_READ:
            begin
                found_o = eidx_ok;
                if (eidx_ok)
                begin
                    rpol_o = r_pol;
                    rmac_o = r_mac;
                    rcls_o = clean(r_cls, unk);
                end
                else
                begin
                    rcls_o = unk;
                end
            end
            default:
            begin
                found_o = 1'b0;
                status  = 1'b1;
            end
        endcase

        ins_full   = (count_reg >= CNT_W'(TABLE_DEPTH));
        t_we       = 1'b0;
        t_waddr    = hit_reg;
        t_wdata    = '0;
        count_next = count_reg;
        if (op_reg == OP_CLEAR)
        begin
            count_next = '0;
        end
        if (do_apply)
        begin
            if (apol == POL_NORMAL)
            begin
                if (tfound_reg)
                begin
                    t_we       = (hit_reg != last_idx);
                    t_wdata    = last_row_reg;
                    count_next = count_reg - 1'b1;
                end
            end
            else if (tfound_reg)
            begin
                t_we    = 1'b1;
                t_wdata = {mac_reg,
                           ((ccls != unk) || (hcls_reg == unk)) ? ccls : hcls_reg,
                           apol};
            end
            else if (ins_full)
            begin
                status = 1'b1;
            end
            else
            begin
                t_we       = 1'b1;
                t_waddr    = count_reg[TIDX_W-1:0];
                t_wdata    = {mac_reg, ccls, apol};
                count_next = count_reg + 1'b1;
            end
        end
        t_we = t_we && cmd.commit;
    end

    // Beat capture, registered compare of the previous scan row, results.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(opcode);
            mac_reg  <= device_mac;
            cls_reg  <= det_class;
            pol_reg  <= policy_code;
            eidx_reg <= entry_index;
        end
        tvidx_reg <= cmd.tidx;
        if (tv_reg && r_mac == mac_reg && !tfound_reg)
        begin
            hit_reg  <= tvidx_reg;
            hpol_reg <= r_pol;
            hcls_reg <= r_cls;
        end
        if (lv_reg)
        begin
            last_row_reg <= t_rdata;
        end
        if (cmd.commit)
        begin
            op_status     <= status;
            entry_found   <= found_o;
            device_policy <= rpol_o;
            is_silenced   <= sil_o;
            entry_mac     <= rmac_o;
            entry_class   <= rcls_o;
            entry_total   <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sfill_reg  <= '0;
            snext_reg  <= '0;
            tfound_reg <= 1'b0;
            sfound_reg <= 1'b0;
            tv_reg     <= 1'b0;
            sv_reg     <= 1'b0;
            lv_reg     <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            tv_reg <= cmd.tscan;
            sv_reg <= cmd.sscan;
            lv_reg <= cmd.rd_last;
            if (cmd.load)
            begin
                tfound_reg <= 1'b0;
                sfound_reg <= 1'b0;
            end
            else
            begin
                if (tv_reg && r_mac == mac_reg)
                begin
                    tfound_reg <= 1'b1;
                end
                if (sv_reg && s_rdata == mac_reg)
                begin
                    sfound_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                out_valid <= 1'b1;
                if (s_we)
                begin
                    snext_reg <= (snext_reg == SIDX_W'(SNOOZE_DEPTH - 1)) ? '0
                                 : snext_reg + 1'b1;
                    if (sfill_reg < CNT_W'(SNOOZE_DEPTH))
                    begin
                        sfill_reg <= sfill_reg + 1'b1;
                    end
                end
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    assign stat.count  = count_reg;
    assign stat.sfill  = sfill_reg;

    `MPF_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH),
                    "entry count above depth")
    `MPF_ASSERT_IMP(a_fill_max, clk, rst_n, 1'b1, sfill_reg <= CNT_W'(SNOOZE_DEPTH),
                    "snooze fill above depth")
    `MPF_ASSERT_NXT(a_cnt_step, clk, rst_n, cmd.commit && op_reg != OP_CLEAR,
                    (count_reg == $past(count_reg)) || (count_reg == $past(count_reg) + 1'b1)
                    || (count_reg == $past(count_reg) - 1'b1), "count jumped")
endmodule
